// ===== rtl/ltok_pkg.sv =====
package ltok_pkg;

    localparam int KIND_W = 5;
    localparam int COLUMN_W = 13;
    localparam int LINE_W = 16;
    localparam int VALUE_W = 64;
    localparam int ERR_W = 2;

    localparam logic [KIND_W-1:0] K_END      = 5'd0;
    localparam logic [KIND_W-1:0] K_NUMBER   = 5'd1;
    localparam logic [KIND_W-1:0] K_STRING   = 5'd2;
    localparam logic [KIND_W-1:0] K_BOOL     = 5'd3;
    localparam logic [KIND_W-1:0] K_IDENT    = 5'd4;
    localparam logic [KIND_W-1:0] K_LT       = 5'd5;
    localparam logic [KIND_W-1:0] K_PLUS     = 5'd6;
    localparam logic [KIND_W-1:0] K_MINUS    = 5'd7;
    localparam logic [KIND_W-1:0] K_STAR     = 5'd8;
    localparam logic [KIND_W-1:0] K_SLASH    = 5'd9;
    localparam logic [KIND_W-1:0] K_COMMA    = 5'd10;
    localparam logic [KIND_W-1:0] K_PERCENT  = 5'd11;
    localparam logic [KIND_W-1:0] K_BANG     = 5'd12;
    localparam logic [KIND_W-1:0] K_LPAREN   = 5'd13;
    localparam logic [KIND_W-1:0] K_RPAREN   = 5'd14;
    localparam logic [KIND_W-1:0] K_EQEQ     = 5'd15;
    localparam logic [KIND_W-1:0] K_ASSIGN   = 5'd16;
    localparam logic [KIND_W-1:0] K_ANDAND   = 5'd17;
    localparam logic [KIND_W-1:0] K_OROR     = 5'd18;
    localparam logic [KIND_W-1:0] K_DO       = 5'd19;
    localparam logic [KIND_W-1:0] K_IF       = 5'd20;
    localparam logic [KIND_W-1:0] K_KW_END   = 5'd21;
    localparam logic [KIND_W-1:0] K_ELSE     = 5'd22;
    localparam logic [KIND_W-1:0] K_WHILE    = 5'd23;
    localparam logic [KIND_W-1:0] K_PRINT    = 5'd24;
    localparam logic [KIND_W-1:0] K_RETURN   = 5'd25;
    localparam logic [KIND_W-1:0] K_FUNCTION = 5'd26;

    localparam logic [ERR_W-1:0] E_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] E_UNKNOWN  = 2'd1;
    localparam logic [ERR_W-1:0] E_QUOTE    = 2'd2;
    localparam logic [ERR_W-1:0] E_OVERFLOW = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [COLUMN_W-1:0] col;
        logic [COLUMN_W-1:0] span;
        logic [VALUE_W-1:0]  value;
        logic                truth;
        logic [ERR_W-1:0]    err;
        logic [LINE_W-1:0]   line;
    } result_t;

endpackage

// ===== rtl/line_tokenizer.sv =====
// line_tokenizer: scans one source line a character per input transaction and
// emits tokens (numbers as unsigned fixed point, strings, operators,
// identifiers and keywords) with their start column and line number.
// input channel: in_valid/in_ready carry character, line_end, line_number.
// a transaction with line_end set flushes any pending token and adds an end
// token; a lexing error gives an end token and drops the rest, line_end too.
// output channel: out_valid/out_ready carry one token per transaction;
// last_of_run marks the final token caused by one input transaction.
// a non-digit character is taken, then each token it causes (at most two) is
// emitted; a digit that extends an integer part steps through S_INT_MUL and
// S_INT_ADD, a fraction digit through S_F_MUL, S_F_ADD and S_F_DIV, on the
// single shared 32x32 multiplier (times-ten, digit weight, divide-by-ten).
// in_ready is low while a character is in work or its tokens are pending, so
// a stalled receiver holds off the next character; tokens are never dropped.
// reset (rst_n low, asynchronous) returns to the between-tokens state, with
// column count and all scan state cleared.
module line_tokenizer #(
    parameter int LINE_LENGTH_MAX = 4096,
    parameter int FRACTION_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    character,
    input  logic                          line_end,
    input  logic [ltok_pkg::LINE_W-1:0]   line_number,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ltok_pkg::KIND_W-1:0]   token_kind,
    output logic [ltok_pkg::COLUMN_W-1:0] start_column,
    output logic [ltok_pkg::COLUMN_W-1:0] span_length,
    output logic [ltok_pkg::VALUE_W-1:0]  number_value,
    output logic                          truth_value,
    output logic [ltok_pkg::ERR_W-1:0]    error_code,
    output logic [ltok_pkg::LINE_W-1:0]   source_line,
    output logic                          last_of_run
);
    import ltok_pkg::*;

    localparam int COL_W = $clog2(LINE_LENGTH_MAX + 1);
    localparam logic [COL_W-1:0] COL_MAX = COL_W'(LINE_LENGTH_MAX);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(LINE_LENGTH_MAX - 1);
    localparam logic [31:0] WEIGHT_INIT = 32'((64'd1 << FRACTION_BITS) / 10);
    localparam logic [31:0] RECIP_TEN = 32'hCCCCCCCD;

    typedef enum logic [3:0] {
        M_IDLE, M_INT, M_FRAC, M_STR, M_IDENT, M_EQ, M_AMP, M_BAR, M_DEAD
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE, S_INT_MUL, S_INT_ADD, S_F_MUL, S_F_ADD, S_F_DIV, S_EMIT
    } seq_t;

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // keyword match on the last bytes of the identifier, n zero for no match
    function automatic logic [KIND_W-1:0] kw_kind(logic [63:0] w, logic [3:0] n);
        logic [KIND_W-1:0] k;
        k = K_IDENT;
        case (n)
            4'd2:
            begin
                if (w[15:0] == 16'h646F) k = K_DO;
                else if (w[15:0] == 16'h6966) k = K_IF;
            end
            4'd3:
            begin
                if (w[23:0] == 24'h656E64) k = K_KW_END;
            end
            4'd4:
            begin
                if (w[31:0] == 32'h656C7365) k = K_ELSE;
                else if (w[31:0] == 32'h74727565) k = K_BOOL;
            end
            4'd5:
            begin
                if (w[39:0] == 40'h7768696C65) k = K_WHILE;
                else if (w[39:0] == 40'h7072696E74) k = K_PRINT;
                else if (w[39:0] == 40'h66616C7365) k = K_BOOL;
            end
            4'd6:
            begin
                if (w[47:0] == 48'h72657475726E) k = K_RETURN;
            end
            4'd8:
            begin
                if (w == 64'h66756E6374696F6E) k = K_FUNCTION;
            end
            default: k = K_IDENT;
        endcase
        return k;
    endfunction

    function automatic result_t mk(logic [KIND_W-1:0] kind, logic [COL_W-1:0] col,
                                   logic [COL_W-1:0] span, logic [VALUE_W-1:0] value,
                                   logic truth, logic [ERR_W-1:0] err,
                                   logic [LINE_W-1:0] line);
        result_t r;
        r.kind = kind;
        r.col = COLUMN_W'(col);
        r.span = COLUMN_W'(span);
        r.value = value;
        r.truth = truth;
        r.err = err;
        r.line = line;
        return r;
    endfunction

    mode_t              mode_reg;
    seq_t               seq_reg;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   tstart_reg;
    logic [COL_W-1:0]   tlen_reg;
    logic [63:0]        window_reg;
    logic [63:0]        acc_reg;
    logic [31:0]        weight_reg;
    logic               ovf_reg;
    logic [LINE_W-1:0]  held_reg;
    logic [63:0]        prod_reg;
    logic [3:0]         digit_reg;
    result_t            pend_reg [2];
    logic [1:0]         pcnt_reg;
    logic               pidx_reg;

    mode_t              mode_next;
    seq_t               seq_next;
    logic [COL_W-1:0]   col_next;
    logic [COL_W-1:0]   tstart_next;
    logic [COL_W-1:0]   tlen_next;
    logic [63:0]        window_next;
    logic [63:0]        acc_next;
    logic [31:0]        weight_next;
    logic               ovf_next;
    logic [LINE_W-1:0]  held_next;
    result_t            pend_next [2];
    logic [1:0]         pcnt_next;

    logic [COL_W-1:0]   col;
    logic [3:0]         digit;
    logic               accept;
    mode_t              st_mode;
    logic               st_put;
    result_t            st_res;
    logic [KIND_W-1:0]  op_kind;
    result_t            num_res;
    result_t            id_res;
    logic [KIND_W-1:0]  id_kind;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        prod_w;
    logic [36:0]        int_sum;

    assign accept = in_valid && in_ready;
    assign in_ready = (seq_reg == S_IDLE);
    assign col = col_reg + COL_W'(1);
    assign digit = 4'(character - "0");

    // shared multiplier
    always_comb
    begin
        mul_a = weight_reg;
        mul_b = RECIP_TEN;
        case (seq_reg)
            S_INT_MUL:
            begin
                mul_a = acc_reg[FRACTION_BITS +: 32];
                mul_b = 32'd10;
            end
            S_F_MUL:  mul_b = 32'(digit_reg);
            default:  mul_b = RECIP_TEN;
        endcase
        prod_w = 64'(mul_a) * 64'(mul_b);
    end

    assign int_sum = prod_reg[36:0] + 37'(digit_reg);

    // pending-token flush values
    always_comb
    begin
        num_res = mk(K_NUMBER, tstart_reg, '0, acc_reg, 1'b0,
                     ovf_reg ? E_OVERFLOW : E_NONE, held_reg);
        id_kind = kw_kind(window_reg, (tlen_reg <= COL_W'(8)) ? 4'(tlen_reg) : 4'd0);
        id_res = mk(id_kind, tstart_reg, (id_kind == K_IDENT) ? tlen_reg : '0, '0,
                    (id_kind == K_BOOL) && (tlen_reg == COL_W'(4)), E_NONE, held_reg);
    end

    // start of a new token at the current character
    always_comb
    begin
        op_kind = K_END;
        case (character)
            "<": op_kind = K_LT;
            "+": op_kind = K_PLUS;
            "-": op_kind = K_MINUS;
            "*": op_kind = K_STAR;
            "/": op_kind = K_SLASH;
            ",": op_kind = K_COMMA;
            "%": op_kind = K_PERCENT;
            "!": op_kind = K_BANG;
            "(": op_kind = K_LPAREN;
            ")": op_kind = K_RPAREN;
            default: op_kind = K_END;
        endcase
        st_put = 1'b0;
        st_res = mk(op_kind, col, '0, '0, 1'b0, E_NONE, line_number);
        if (is_space(character)) st_mode = M_IDLE;
        else if (is_digit(character)) st_mode = M_INT;
        else if (is_alpha(character)) st_mode = M_IDENT;
        else if (character == "\"") st_mode = M_STR;
        else if (character == "=") st_mode = M_EQ;
        else if (character == "&") st_mode = M_AMP;
        else if (character == "|") st_mode = M_BAR;
        else if (op_kind != K_END)
        begin
            st_mode = M_IDLE;
            st_put = 1'b1;
        end
        else
        begin
            st_mode = M_DEAD;
            st_put = 1'b1;
            st_res.err = E_UNKNOWN;
        end
    end

    always_comb
    begin
        logic do_start;
        do_start = 1'b0;
        mode_next = mode_reg;
        seq_next = S_IDLE;
        col_next = (col_reg < COL_LAST) ? col : col_reg;
        tstart_next = tstart_reg;
        tlen_next = tlen_reg;
        window_next = window_reg;
        acc_next = acc_reg;
        weight_next = weight_reg;
        ovf_next = ovf_reg;
        held_next = held_reg;
        pend_next = pend_reg;
        pcnt_next = 2'd0;
        if (line_end)
        begin
            case (mode_reg)
                M_INT, M_FRAC:
                begin
                    pend_next[0] = num_res;
                    pcnt_next = 2'd1;
                end
                M_IDENT:
                begin
                    pend_next[0] = id_res;
                    pcnt_next = 2'd1;
                end
                M_EQ:
                begin
                    pend_next[0] = mk(K_ASSIGN, tstart_reg, '0, '0, 1'b0, E_NONE, held_reg);
                    pcnt_next = 2'd1;
                end
                M_STR:
                begin
                    pend_next[0] = mk(K_STRING, tstart_reg, tlen_reg, '0, 1'b0, E_QUOTE,
                                      held_reg);
                    pcnt_next = 2'd1;
                end
                default: pcnt_next = 2'd0;
            endcase
            if (mode_reg == M_AMP || mode_reg == M_BAR)
            begin
                pend_next[0] = mk(K_END, tstart_reg, '0, '0, 1'b0, E_UNKNOWN, line_number);
                pcnt_next = 2'd1;
            end
            else if (mode_reg != M_DEAD)
            begin
                pend_next[pcnt_next[0]] = mk(K_END, col, '0, '0, 1'b0, E_NONE, line_number);
                pcnt_next = pcnt_next + 2'd1;
            end
            mode_next = M_IDLE;
            col_next = '0;
            tstart_next = '0;
            tlen_next = '0;
            window_next = '0;
            acc_next = '0;
            weight_next = '0;
            ovf_next = 1'b0;
            held_next = '0;
        end
        else
        begin
            case (mode_reg)
                M_INT:
                begin
                    if (is_digit(character)) seq_next = S_INT_MUL;
                    else if (character == ".")
                    begin
                        mode_next = M_FRAC;
                        weight_next = WEIGHT_INIT;
                    end
                    else
                    begin
                        pend_next[0] = num_res;
                        pcnt_next = 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_FRAC:
                begin
                    if (is_digit(character)) seq_next = S_F_MUL;
                    else
                    begin
                        pend_next[0] = num_res;
                        pcnt_next = 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_STR:
                begin
                    if (character == "\"")
                    begin
                        pend_next[0] = mk(K_STRING, tstart_reg, tlen_reg, '0, 1'b0, E_NONE,
                                          held_reg);
                        pcnt_next = 2'd1;
                        mode_next = M_IDLE;
                    end
                    else tlen_next = (tlen_reg < COL_MAX) ? tlen_reg + COL_W'(1) : COL_MAX;
                end
                M_IDENT:
                begin
                    if (is_alpha(character) || is_digit(character))
                    begin
                        tlen_next = (tlen_reg < COL_MAX) ? tlen_reg + COL_W'(1) : COL_MAX;
                        window_next = {window_reg[55:0], character};
                    end
                    else
                    begin
                        pend_next[0] = id_res;
                        pcnt_next = 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_EQ:
                begin
                    pcnt_next = 2'd1;
                    if (character == "=")
                    begin
                        pend_next[0] = mk(K_EQEQ, tstart_reg, '0, '0, 1'b0, E_NONE, held_reg);
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        pend_next[0] = mk(K_ASSIGN, tstart_reg, '0, '0, 1'b0, E_NONE,
                                          held_reg);
                        do_start = 1'b1;
                    end
                end
                M_AMP, M_BAR:
                begin
                    pcnt_next = 2'd1;
                    if ((mode_reg == M_AMP && character == "&")
                        || (mode_reg == M_BAR && character == "|"))
                    begin
                        pend_next[0] = mk((mode_reg == M_AMP) ? K_ANDAND : K_OROR, tstart_reg,
                                          '0, '0, 1'b0, E_NONE, held_reg);
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        pend_next[0] = mk(K_END, tstart_reg, '0, '0, 1'b0, E_UNKNOWN,
                                          line_number);
                        mode_next = M_DEAD;
                    end
                end
                M_DEAD: pcnt_next = 2'd0;
                default: do_start = 1'b1;
            endcase
            if (do_start)
            begin
                mode_next = st_mode;
                tstart_next = col;
                held_next = line_number;
                if (st_mode == M_INT)
                begin
                    ovf_next = 1'b0;
                    acc_next = 64'(digit) << FRACTION_BITS;
                end
                if (st_mode == M_IDENT)
                begin
                    tlen_next = COL_W'(1);
                    window_next = 64'(character);
                end
                if (st_mode == M_STR) tlen_next = '0;
                if (st_put)
                begin
                    pend_next[pcnt_next[0]] = st_res;
                    pcnt_next = pcnt_next + 2'd1;
                end
            end
        end
        if (pcnt_next != 2'd0) seq_next = S_EMIT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            seq_reg <= S_IDLE;
            col_reg <= '0;
            tstart_reg <= '0;
            tlen_reg <= '0;
            window_reg <= '0;
            acc_reg <= '0;
            weight_reg <= '0;
            ovf_reg <= 1'b0;
            held_reg <= '0;
            pcnt_reg <= 2'd0;
            pidx_reg <= 1'b0;
        end
        else
        begin
            case (seq_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg <= mode_next;
                        seq_reg <= seq_next;
                        col_reg <= col_next;
                        tstart_reg <= tstart_next;
                        tlen_reg <= tlen_next;
                        window_reg <= window_next;
                        acc_reg <= acc_next;
                        weight_reg <= weight_next;
                        ovf_reg <= ovf_next;
                        held_reg <= held_next;
                        pend_reg <= pend_next;
                        pcnt_reg <= pcnt_next;
                        pidx_reg <= 1'b0;
                        digit_reg <= digit;
                    end
                end
                S_INT_MUL:
                begin
                    prod_reg <= prod_w;
                    seq_reg <= S_INT_ADD;
                end
                S_INT_ADD:
                begin
                    // integer part saturates at all ones
                    if (int_sum > 37'h0FFFFFFFF)
                    begin
                        acc_reg <= 64'(32'hFFFFFFFF) << FRACTION_BITS;
                        ovf_reg <= 1'b1;
                    end
                    else acc_reg <= 64'(int_sum[31:0]) << FRACTION_BITS;
                    seq_reg <= S_IDLE;
                end
                S_F_MUL:
                begin
                    prod_reg <= prod_w;
                    seq_reg <= S_F_ADD;
                end
                S_F_ADD:
                begin
                    acc_reg <= acc_reg + prod_reg;
                    prod_reg <= prod_w;
                    seq_reg <= S_F_DIV;
                end
                S_F_DIV:
                begin
                    // reciprocal multiply gives the exact floor of weight / 10
                    weight_reg <= 32'(prod_reg >> 35);
                    seq_reg <= S_IDLE;
                end
                S_EMIT:
                begin
                    if (out_ready)
                    begin
                        if (last_of_run)
                        begin
                            seq_reg <= S_IDLE;
                            pidx_reg <= 1'b0;
                        end
                        else pidx_reg <= 1'b1;
                    end
                end
                default: seq_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = (seq_reg == S_EMIT);
    assign token_kind = pend_reg[pidx_reg].kind;
    assign start_column = pend_reg[pidx_reg].col;
    assign span_length = pend_reg[pidx_reg].span;
    assign number_value = pend_reg[pidx_reg].value;
    assign truth_value = pend_reg[pidx_reg].truth;
    assign error_code = pend_reg[pidx_reg].err;
    assign source_line = pend_reg[pidx_reg].line;
    assign last_of_run = (2'(pidx_reg) + 2'd1 == pcnt_reg);

`ifndef SYNTHESIS
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input ready while tokens pending");
    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pcnt_reg != 2'd0 && pcnt_reg != 2'd3))
        else $error("emitting with bad token count");
    a_eol_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && line_end) |=> (col_reg == '0 && mode_reg == M_IDLE))
        else $error("line end did not clear scan state");
    a_int_nofrac: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_INT && seq_reg == S_IDLE) |-> acc_reg[FRACTION_BITS-1:0] == '0)
        else $error("integer scan carries a fraction");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

import ltok_pkg::*;

typedef enum {
    S_IDLE, S_INT, S_FRAC, S_STR, S_IDENT, S_EQ, S_AMP, S_BAR, S_DEAD
} scan_t;

class token_scoreboard;
    localparam int unsigned COL_MAX = 4096;

    scan_t       mode;
    int unsigned colcnt;
    int unsigned tstart;
    int unsigned tlen;
    bit [63:0]   kwin;
    bit [63:0]   acc;
    bit [31:0]   fweight;
    bit          ovf;
    bit [15:0]   hline;

    result_t     expq[$];
    bit          lastq[$];
    result_t     stepq[$];
    int          errors;

    string       words[10] = '{"do", "if", "end", "else", "while", "print", "return",
                               "function", "true", "false"};
    logic [4:0]  word_kinds[10] = '{K_DO, K_IF, K_KW_END, K_ELSE, K_WHILE, K_PRINT,
                                    K_RETURN, K_FUNCTION, K_BOOL, K_BOOL};

    function new();
        errors = 0;
        clear();
    endfunction

    function void clear();
        mode = S_IDLE;
        colcnt = 0;
        tstart = 0;
        tlen = 0;
        kwin = 0;
        acc = 0;
        fweight = 0;
        ovf = 0;
        hline = 0;
    endfunction

    function int pending();
        return expq.size();
    endfunction

    function bit is_digit(bit [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function bit is_alpha(bit [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_space(bit [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function void put(logic [4:0] kind, int unsigned col, int unsigned span,
                      bit [63:0] value, bit truth, logic [1:0] err, bit [15:0] ln);
        result_t t;
        if (stepq.size() < 3)
        begin
            t.kind = kind;
            t.col = col[12:0];
            t.span = span[12:0];
            t.value = value;
            t.truth = truth;
            t.err = err;
            t.line = ln;
            stepq.push_back(t);
        end
    endfunction

    function void flush_number();
        put(K_NUMBER, tstart, 0, acc, 0, ovf ? E_OVERFLOW : E_NONE, hline);
    endfunction

    function void flush_ident();
        bit [63:0] pw;
        bit [63:0] mask;
        if (tlen <= 8)
        begin
            mask = (tlen == 8) ? '1 : ((64'd1 << (8 * tlen)) - 1);
            for (int i = 0; i < 10; i++)
            begin
                if (words[i].len() != tlen)
                    continue;
                pw = 0;
                for (int j = 0; j < words[i].len(); j++)
                    pw = (pw << 8) | words[i][j];
                if (pw == (kwin & mask))
                begin
                    put(word_kinds[i], tstart, 0, 0, i == 8, E_NONE, hline);
                    return;
                end
            end
        end
        put(K_IDENT, tstart, tlen, 0, 0, E_NONE, hline);
    endfunction

    function void start_token(bit [7:0] c, int unsigned col, bit [15:0] ln);
        logic [4:0] op;
        op = K_END;
        mode = S_IDLE;
        tstart = col;
        hline = ln;
        if (is_space(c))
            return;
        if (is_digit(c))
        begin
            mode = S_INT;
            ovf = 0;
            acc = 64'(c - "0") << 32;
            return;
        end
        if (is_alpha(c))
        begin
            mode = S_IDENT;
            tlen = 1;
            kwin = c;
            return;
        end
        case (c)
            "\"":
            begin
                mode = S_STR;
                tlen = 0;
                return;
            end
            "=":
            begin
                mode = S_EQ;
                return;
            end
            "&":
            begin
                mode = S_AMP;
                return;
            end
            "|":
            begin
                mode = S_BAR;
                return;
            end
            "<": op = K_LT;
            "+": op = K_PLUS;
            "-": op = K_MINUS;
            "*": op = K_STAR;
            "/": op = K_SLASH;
            ",": op = K_COMMA;
            "%": op = K_PERCENT;
            "!": op = K_BANG;
            "(": op = K_LPAREN;
            ")": op = K_RPAREN;
            default: op = K_END;
        endcase
        if (op != K_END)
            put(op, col, 0, 0, 0, E_NONE, ln);
        else
        begin
            put(K_END, col, 0, 0, 0, E_UNKNOWN, ln);
            mode = S_DEAD;
        end
    endfunction

    // works out the tokens caused by one accepted input transaction
    function void note_input(bit [7:0] c, bit eol, bit [15:0] ln);
        int unsigned col;
        bit          end_needed;
        bit [63:0]   ip;
        col = colcnt + 1;
        stepq.delete();
        if (eol)
        begin
            end_needed = 1;
            case (mode)
                S_INT, S_FRAC: flush_number();
                S_IDENT: flush_ident();
                S_EQ: put(K_ASSIGN, tstart, 0, 0, 0, E_NONE, hline);
                S_STR: put(K_STRING, tstart, tlen, 0, 0, E_QUOTE, hline);
                S_AMP, S_BAR:
                begin
                    put(K_END, tstart, 0, 0, 0, E_UNKNOWN, ln);
                    end_needed = 0;
                end
                S_DEAD: end_needed = 0;
                default: ;
            endcase
            if (end_needed)
                put(K_END, col, 0, 0, 0, E_NONE, ln);
            clear();
        end
        else
        begin
            case (mode)
                S_INT:
                    if (is_digit(c))
                    begin
                        ip = (acc >> 32) * 10 + (c - "0");
                        if (ip > 64'hFFFF_FFFF)
                        begin
                            ip = 64'hFFFF_FFFF;
                            ovf = 1;
                        end
                        acc = ip << 32;
                    end
                    else if (c == ".")
                    begin
                        mode = S_FRAC;
                        fweight = 32'd429496729;
                    end
                    else
                    begin
                        flush_number();
                        start_token(c, col, ln);
                    end
                S_FRAC:
                    if (is_digit(c))
                    begin
                        acc += 64'(c - "0") * fweight;
                        fweight /= 10;
                    end
                    else
                    begin
                        flush_number();
                        start_token(c, col, ln);
                    end
                S_STR:
                    if (c == "\"")
                    begin
                        put(K_STRING, tstart, tlen, 0, 0, E_NONE, hline);
                        mode = S_IDLE;
                    end
                    else if (tlen < COL_MAX)
                        tlen++;
                S_IDENT:
                    if (is_alpha(c) || is_digit(c))
                    begin
                        if (tlen < COL_MAX)
                            tlen++;
                        kwin = (kwin << 8) | c;
                    end
                    else
                    begin
                        flush_ident();
                        start_token(c, col, ln);
                    end
                S_EQ:
                    if (c == "=")
                    begin
                        put(K_EQEQ, tstart, 0, 0, 0, E_NONE, hline);
                        mode = S_IDLE;
                    end
                    else
                    begin
                        put(K_ASSIGN, tstart, 0, 0, 0, E_NONE, hline);
                        start_token(c, col, ln);
                    end
                S_AMP, S_BAR:
                    if (c == ((mode == S_AMP) ? "&" : "|"))
                    begin
                        put((mode == S_AMP) ? K_ANDAND : K_OROR, tstart, 0, 0, 0, E_NONE,
                            hline);
                        mode = S_IDLE;
                    end
                    else
                    begin
                        put(K_END, tstart, 0, 0, 0, E_UNKNOWN, ln);
                        mode = S_DEAD;
                    end
                S_DEAD: ;
                default: start_token(c, col, ln);
            endcase
            if (colcnt < COL_MAX - 1)
                colcnt++;
        end
        foreach (stepq[i])
        begin
            expq.push_back(stepq[i]);
            lastq.push_back(i == stepq.size() - 1);
        end
    endfunction

    function void check_result(result_t got, bit got_last);
        result_t e;
        bit      e_last;
        if (expq.size() == 0)
        begin
            $error("unexpected token kind %0d col %0d", got.kind, got.col);
            errors++;
            return;
        end
        e = expq.pop_front();
        e_last = lastq.pop_front();
        if (got.kind !== e.kind)
        begin
            $error("token_kind expected %0d got %0d", e.kind, got.kind);
            errors++;
        end
        if (got.col !== e.col)
        begin
            $error("start_column expected %0d got %0d", e.col, got.col);
            errors++;
        end
        if (got.span !== e.span)
        begin
            $error("span_length expected %0d got %0d", e.span, got.span);
            errors++;
        end
        if (got.value !== e.value)
        begin
            $error("number_value expected %h got %h", e.value, got.value);
            errors++;
        end
        if (got.truth !== e.truth)
        begin
            $error("truth_value expected %0d got %0d", e.truth, got.truth);
            errors++;
        end
        if (got.err !== e.err)
        begin
            $error("error_code expected %0d got %0d", e.err, got.err);
            errors++;
        end
        if (got.line !== e.line)
        begin
            $error("source_line expected %0d got %0d", e.line, got.line);
            errors++;
        end
        if (got_last !== e_last)
        begin
            $error("last_of_run expected %0d got %0d", e_last, got_last);
            errors++;
        end
    endfunction
endclass

module tb;
    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [7:0]          character;
    logic                line_end;
    logic [LINE_W-1:0]   line_number;
    logic                out_valid;
    logic                out_ready;
    logic [KIND_W-1:0]   token_kind;
    logic [COLUMN_W-1:0] start_column;
    logic [COLUMN_W-1:0] span_length;
    logic [VALUE_W-1:0]  number_value;
    logic                truth_value;
    logic [ERR_W-1:0]    error_code;
    logic [LINE_W-1:0]   source_line;
    logic                last_of_run;

    token_scoreboard sb = new();
    bit              calm;
    int              stall_left;
    int              items_sent;
    bit [7:0]        line_buf[$];

    line_tokenizer i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .character(character), .line_end(line_end), .line_number(line_number),
        .out_valid(out_valid), .out_ready(out_ready),
        .token_kind(token_kind), .start_column(start_column),
        .span_length(span_length), .number_value(number_value),
        .truth_value(truth_value), .error_code(error_code),
        .source_line(source_line), .last_of_run(last_of_run)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // both transactions noted in one process so ordering within a step is fixed
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_input(character, line_end, line_number);
            if (out_valid && out_ready)
                sb.check_result('{token_kind, start_column, span_length, number_value,
                                  truth_value, error_code, source_line}, last_of_run);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (stall_left > 0)
                stall_left--;
            else if (!calm && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            out_ready <= (stall_left == 0);
        end
    end

    task send_item(bit [7:0] c, bit eol, bit [15:0] ln);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        character <= c;
        line_end <= eol;
        line_number <= ln;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task send_buf(bit [15:0] ln);
        foreach (line_buf[i])
            send_item(line_buf[i], 1'b0, ln);
        send_item($urandom_range(0, 255), 1'b1, ln);
        line_buf.delete();
    endtask

    task add_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    task send_text(string s, bit [15:0] ln);
        add_text(s);
        send_buf(ln);
    endtask

    task add_lexeme();
        string ops[16] = '{"<", "+", "-", "*", "/", ",", "%", "!", "(", ")", "==", "=",
                           "&&", "||", "&", "|"};
        int    n;
        case ($urandom_range(0, 11))
            0, 1, 2:
            begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 4);
                repeat (n) line_buf.push_back("0" + $urandom_range(0, 9));
                if ($urandom_range(0, 1))
                begin
                    line_buf.push_back(".");
                    repeat ($urandom_range(0, 11)) line_buf.push_back("0" + $urandom_range(0, 9));
                end
            end
            3:
                add_text(sb.words[$urandom_range(0, 9)]);
            4, 5:
            begin
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++)
                begin
                    if (i > 0 && $urandom_range(0, 3) == 0)
                        line_buf.push_back("0" + $urandom_range(0, 9));
                    else if ($urandom_range(0, 1))
                        line_buf.push_back("a" + $urandom_range(0, 25));
                    else
                        line_buf.push_back("A" + $urandom_range(0, 25));
                end
            end
            6:
            begin
                line_buf.push_back("\"");
                repeat ($urandom_range(0, 6))
                begin
                    n = $urandom_range(0, 255);
                    line_buf.push_back(n == "\"" ? "x" : n);
                end
                if ($urandom_range(0, 5) != 0)
                    line_buf.push_back("\"");
            end
            7, 8, 9, 10:
                add_text(ops[$urandom_range(0, 15)]);
            default:
                line_buf.push_back($urandom_range(0, 255));
        endcase
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        character = '0;
        line_end = 1'b0;
        line_number = '0;
        calm = 1'b0;
        stall_left = 0;
        items_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: operators, keywords, numbers, overflow, strings, errors
        send_text("a==b=c&&d||e<+-*/,%!()", 16'd0);
        send_text("do if end else while print return function true false", 16'hFFFF);
        send_text("4294967295 4294967296 12. 0.5 3.14159265358", 16'h1234);
        send_text("functions x1=\"hi\"\"", 16'd7);
        send_text("a&b", 16'd8);
        send_text("x|", 16'd9);
        line_buf.push_back("1");
        line_buf.push_back(8'd9);
        line_buf.push_back(8'hFF);
        line_buf.push_back("z");
        send_buf(16'd10);
        send_text("v=", 16'd11);
        send_item("q", 1'b1, 16'd12);

        // hold off until everything has drained
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);

        while (items_sent < 170)
        begin
            calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 6))
            begin
                add_lexeme();
                if ($urandom_range(0, 3) != 0)
                    line_buf.push_back($urandom_range(0, 4) == 0 ? 8'd9 : " ");
            end
            send_buf($urandom_range(0, 65535));
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("line_tokenizer: match");
        else
            $display("line_tokenizer: mismatch");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("line_tokenizer: mismatch");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/ltok_pkg.sv
rtl/line_tokenizer.sv
tb/sv/tb.sv
